>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the trip guard.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define OTG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define OTG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define OTG_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/otg_pkg.sv
// Package of the overcurrent trip guard: op codes, register indexes,
// field widths and configuration reset values. No dependencies.
package otg_pkg;

  localparam int unsigned MagW     = 15;
  localparam int unsigned LoadW    = 16;
  localparam int unsigned StampW   = 32;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned OpW      = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 56;

  localparam logic [MagW-1:0]   MagMax      = 15'h7fff;
  localparam logic [DelayW-1:0] HoldDefault = 16'd2000;

  typedef enum logic [OpW-1:0] {
    OP_UPDATE      = 3'd0,
    OP_BUTTON      = 3'd1,
    OP_FORCE_TRIP  = 3'd2,
    OP_TRY_RESET   = 3'd3,
    OP_FORCE_RESET = 3'd4
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TRIP_MA           = 3'd0,
    REG_TRIP_DELAY_MS     = 3'd1,
    REG_LATCH_MODE        = 3'd2,
    REG_RETRY_DELAY_MS    = 3'd3,
    REG_RESET_SAFE_MA     = 3'd4,
    REG_BUTTON_ENABLE     = 3'd5,
    REG_BUTTON_ACTIVE_LOW = 3'd6,
    REG_BUTTON_HOLD_MS    = 3'd7
  } reg_idx_t;

  // Configuration register file.
  typedef struct packed {
    logic [MagW-1:0]   trip_ma;
    logic [DelayW-1:0] trip_delay_ms;
    logic              latch_mode;
    logic [DelayW-1:0] retry_delay_ms;
    logic [MagW-1:0]   reset_safe_ma;
    logic              button_enable;
    logic              button_active_low;
    logic [DelayW-1:0] button_hold_ms;
  } cfg_t;

  // Protection state carried from word to word.
  typedef struct packed {
    logic              trip_flag;
    logic [StampW-1:0] over_start;
    logic [MagW-1:0]   load_mag;
    logic [StampW-1:0] trip_stamp;
    logic [StampW-1:0] hold_start;
  } guard_state_t;

endpackage

>>> hdl/overcurrent_trip_guard_top.sv
// Overcurrent trip guard (electronic fuse) top level.
// Depends on otg_pkg for op codes, register indexes and state types.
//
// Usage:
//   in_*  : input words. in_tuser[2:0] = op; in_tdata holds load_ma (signed
//           mA), now_ms (ms timestamp) and button_level.
//   out_* : one result word per input word: load_allowed, reset_done,
//           last_load_ma and last_trip_ms.
//   cfg_* : register writes, index 0..7, taken whenever cfg_ready is high.
//           Write registers only while no word is in flight.
// Path: an accepted word passes the input register, then the result register,
//   and shows on out_*; a low out_tready can hold it in either register.
// Throughput: one word per cycle unless out_tready stalls; the state update is
//   a single pass of compares and 32-bit subtractions between the registers.
// Reset: rst_n low clears the trip, all timing stamps and both pipeline
//   stages and loads register defaults (button active low, hold 2000 ms).
//   in_tready and cfg_ready are low while reset is held.
// Stall: while out_tready is low the result holds; the input register
//   still takes one more word, then in_tready drops until the result leaves.
module overcurrent_trip_guard_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: load_ma[15:0], now_ms[47:16], button_level[48], zeros[55:49]
  input  logic [otg_pkg::InDataW-1:0]    in_tdata,
  // in_tuser: op[2:0]
  input  logic [otg_pkg::OpW-1:0]        in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // out_tdata: load_allowed[0], reset_done[1], last_load_ma[16:2],
  //            last_trip_ms[48:17], zeros[55:49]
  output logic [otg_pkg::OutDataW-1:0]   out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [otg_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [otg_pkg::CfgDataW-1:0]   cfg_data
);

  localparam logic [otg_pkg::StampW-1:0] StampZero = '0;

  // Input register.
  logic                          s0_valid_r;
  logic [otg_pkg::OpW-1:0]       s0_op_r;
  logic signed [otg_pkg::LoadW-1:0] s0_load_ma_r;
  logic [otg_pkg::StampW-1:0]    s0_now_r;
  logic                          s0_level_r;

  // Result register.
  logic                          out_valid_r;
  logic                          out_allowed_r;
  logic                          out_done_r;
  logic [otg_pkg::MagW-1:0]      out_mag_r;
  logic [otg_pkg::StampW-1:0]    out_trip_r;

  otg_pkg::cfg_t                 cfg_r;
  otg_pkg::cfg_t                 cfg_nxt;
  otg_pkg::guard_state_t         st_r;
  otg_pkg::guard_state_t         st_nxt;
  logic                          done_nxt;

  logic                          advance;
  logic                          in_fire;
  logic [otg_pkg::LoadW-1:0]     neg_load;
  logic [otg_pkg::MagW-1:0]      mag;

  // Pipeline control: the result register frees up when it is empty or taken.
  assign advance   = s0_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!s0_valid_r || advance);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = rst_n;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_trip_r, out_mag_r, out_done_r, out_allowed_r};

  // Magnitude of the signed current, saturating the most negative code.
  always_comb begin
    neg_load = otg_pkg::LoadW'(16'd0 - $unsigned(s0_load_ma_r));
    if (!s0_load_ma_r[otg_pkg::LoadW-1]) begin
      mag = s0_load_ma_r[otg_pkg::MagW-1:0];
    end else if (neg_load[otg_pkg::LoadW-1]) begin
      mag = otg_pkg::MagMax;
    end else begin
      mag = neg_load[otg_pkg::MagW-1:0];
    end
  end

  // Next protection state for the word in the input register.
  always_comb begin
    logic                       tripped;
    logic                       proceed;
    logic [otg_pkg::StampW-1:0] start;
    logic                       pressed;
    logic [otg_pkg::StampW-1:0] hstart;

    st_nxt   = st_r;
    done_nxt = 1'b0;
    tripped  = st_r.trip_flag;
    proceed  = 1'b0;
    start    = StampZero;
    pressed  = 1'b0;
    hstart   = StampZero;

    case (s0_op_r)
      otg_pkg::OP_UPDATE: begin
        st_nxt.load_mag = mag;
        // Auto retry clears the trip once the cooldown has run out.
        if (!tripped) begin
          proceed = 1'b1;
        end else if (!cfg_r.latch_mode && (cfg_r.retry_delay_ms != '0) &&
                     ((s0_now_r - st_r.trip_stamp) >=
                      {16'd0, cfg_r.retry_delay_ms})) begin
          proceed = 1'b1;
          st_nxt.trip_flag  = 1'b0;
          st_nxt.over_start = StampZero;
        end
        if (proceed) begin
          if (mag > cfg_r.trip_ma) begin
            start = (st_nxt.over_start == StampZero) ? s0_now_r : st_nxt.over_start;
            st_nxt.over_start = start;
            if ((s0_now_r - start) >= {16'd0, cfg_r.trip_delay_ms}) begin
              st_nxt.trip_flag  = 1'b1;
              st_nxt.trip_stamp = s0_now_r;
            end
          end else begin
            st_nxt.over_start = StampZero;
          end
        end
      end
      otg_pkg::OP_BUTTON: begin
        if (cfg_r.button_enable) begin
          if (!tripped) begin
            st_nxt.hold_start = StampZero;
          end else begin
            pressed = cfg_r.button_active_low ? !s0_level_r : s0_level_r;
            if (pressed) begin
              hstart = (st_r.hold_start == StampZero) ? s0_now_r : st_r.hold_start;
              st_nxt.hold_start = hstart;
              // Hold complete: try a reset and restart hold timing.
              if ((s0_now_r - hstart) >= {16'd0, cfg_r.button_hold_ms}) begin
                st_nxt.hold_start = StampZero;
                if (mag <= cfg_r.reset_safe_ma) begin
                  st_nxt.trip_flag  = 1'b0;
                  st_nxt.over_start = StampZero;
                  done_nxt          = 1'b1;
                end
              end
            end else begin
              st_nxt.hold_start = StampZero;
            end
          end
        end
      end
      otg_pkg::OP_FORCE_TRIP: begin
        st_nxt.trip_flag  = 1'b1;
        st_nxt.trip_stamp = s0_now_r;
        st_nxt.over_start = StampZero;
      end
      otg_pkg::OP_TRY_RESET: begin
        if (mag <= cfg_r.reset_safe_ma) begin
          st_nxt.trip_flag  = 1'b0;
          st_nxt.over_start = StampZero;
          done_nxt          = 1'b1;
        end
      end
      otg_pkg::OP_FORCE_RESET: begin
        st_nxt.trip_flag  = 1'b0;
        st_nxt.over_start = StampZero;
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  // Decode register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        otg_pkg::REG_TRIP_MA:           cfg_nxt.trip_ma = cfg_data[otg_pkg::MagW-1:0];
        otg_pkg::REG_TRIP_DELAY_MS:     cfg_nxt.trip_delay_ms = cfg_data;
        otg_pkg::REG_LATCH_MODE:        cfg_nxt.latch_mode = cfg_data[0];
        otg_pkg::REG_RETRY_DELAY_MS:    cfg_nxt.retry_delay_ms = cfg_data;
        otg_pkg::REG_RESET_SAFE_MA:     cfg_nxt.reset_safe_ma = cfg_data[otg_pkg::MagW-1:0];
        otg_pkg::REG_BUTTON_ENABLE:     cfg_nxt.button_enable = cfg_data[0];
        otg_pkg::REG_BUTTON_ACTIVE_LOW: cfg_nxt.button_active_low = cfg_data[0];
        otg_pkg::REG_BUTTON_HOLD_MS:    cfg_nxt.button_hold_ms = cfg_data;
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold configuration and protection state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trip_ma           <= '0;
      cfg_r.trip_delay_ms     <= '0;
      cfg_r.latch_mode        <= 1'b0;
      cfg_r.retry_delay_ms    <= '0;
      cfg_r.reset_safe_ma     <= '0;
      cfg_r.button_enable     <= 1'b0;
      cfg_r.button_active_low <= 1'b1;
      cfg_r.button_hold_ms    <= otg_pkg::HoldDefault;
      st_r                    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // Advance the valid flags of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s0_valid_r <= 1'b1;
      end else if (advance) begin
        s0_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the input word and the result word.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_op_r      <= in_tuser;
      s0_load_ma_r <= $signed(in_tdata[15:0]);
      s0_now_r     <= in_tdata[47:16];
      s0_level_r   <= in_tdata[48];
    end
    if (advance) begin
      out_allowed_r <= !st_nxt.trip_flag;
      out_done_r    <= done_nxt;
      out_mag_r     <= st_nxt.load_mag;
      out_trip_r    <= st_nxt.trip_stamp;
    end
  end

endmodule

>>> hdl/otg_checker.sv
// Port-level checker for the overcurrent trip guard, bound to the top level.
// Depends on otg_pkg widths and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module otg_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [otg_pkg::OutDataW-1:0] out_tdata,
  input logic                         out_tvalid,
  input logic                         out_tready
);

  // A stalled result holds its word.
  `OTG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result word changed")

  // A successful reset always leaves the load allowed.
  `OTG_ASSERT_IMPL(a_done_allows, clk, rst_n, out_tvalid && out_tdata[1], out_tdata[0], "reset_done without load_allowed")

  // A new result follows an accepted word through the input and result registers.
  `OTG_ASSERT_IMPL(a_latency, clk, rst_n, $rose(out_tvalid), $past(in_tvalid && in_tready, 2), "result without matching input word")

  // Reset empties the result stage.
  `OTG_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, !rst_n, !out_tvalid, "result valid right after reset")

endmodule

bind overcurrent_trip_guard_top otg_checker u_otg_checker (.*);
